[src/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int unsigned CNT_W  = 17;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned DIST_W = 19;
  localparam int unsigned MUL_W  = 11;
  localparam int unsigned PROD_W = TICK_W + MUL_W;

  // 0.01715 cm per tick in Q16, rounded
  localparam logic [MUL_W-1:0] DIST_MUL = 11'd1124;

  // configuration register indexes
  localparam logic [1:0] CFG_SETTLE  = 2'd0;
  localparam logic [1:0] CFG_TRIGGER = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [7:0]  SETTLE_RST  = 8'd2;
  localparam logic [7:0]  TRIGGER_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST = 16'd30000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_TRIGGER,
    PH_WAIT_RISE,
    PH_WAIT_FALL
  } phase_t;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [7:0]  trigger_ticks;
    logic [15:0] timeout_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } uer_in_t;

  typedef struct packed {
    logic              drive_enable;
    logic              drive_level;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic              timeout_phase;
    logic [TICK_W-1:0] pulse_ticks;
    logic [DIST_W-1:0] distance_q8_cm;
  } uer_out_t;

endpackage

[src/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger: takes one microsecond tick per transfer and returns
// one result per tick. An accepted tick is registered, stepped through the
// phase sequencer and its result registered. One tick is taken every cycle
// while the output is not stalled; the single phase/count update per tick
// is the loop that sets this rate. Result stalls are held in the input and
// output registers and pushed back through in_ready. Configuration writes
// are always ready and take effect on the next tick stepped.
// Depends on uer_pkg, uer_cfg_regs and uer_core.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  uer_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output uer_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t cfg;
  logic      s1_valid;
  uer_in_t   s1_data;
  logic      s1_advance;
  uer_out_t  core_res;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  uer_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  uer_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (s1_advance),
    .item    (s1_data),
    .cfg     (cfg),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= core_res;
    end
  end

`ifndef SYNTHESIS
  // an input transfer always lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("input transfer lost");

  // a stepped tick shows its own result next cycle
  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> (out_valid && out_data == $past(core_res)))
    else $error("result register not loaded from core");

  // reset empties both registers
  a_rst_clear: assert property (@(posedge clk)
    $past(rst) |-> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

[src/uer_cfg_regs.sv]
// Configuration register bank: settle, trigger and timeout lengths.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_regs_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.settle_ticks  <= SETTLE_RST;
      regs.trigger_ticks <= TRIGGER_RST;
      regs.timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SETTLE:  regs.settle_ticks  <= wr_data[7:0];
        CFG_TRIGGER: regs.trigger_ticks <= wr_data[7:0];
        CFG_TIMEOUT: regs.timeout_ticks <= wr_data;
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule

[src/uer_core.sv]
// Per-tick sequencer: phase/count state and the result for one tick.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_core
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  uer_in_t   item,
  input  cfg_regs_t cfg,
  output uer_out_t  res
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] phase_count, phase_count_next;

  phase_t           ph_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             timeout_hit;
  logic [PROD_W-1:0] prod;

  // Phases that end at the start of this tick fall through in the same tick
  always_comb begin
    ph_eff  = phase;
    cnt_eff = phase_count;
    if (ph_eff == PH_IDLE && item.start_request) begin
      ph_eff  = PH_SETTLE;
      cnt_eff = '0;
    end
    if (ph_eff == PH_SETTLE && cnt_eff >= {{(CNT_W-8){1'b0}}, cfg.settle_ticks}) begin
      ph_eff  = PH_TRIGGER;
      cnt_eff = '0;
    end
    if (ph_eff == PH_TRIGGER && cnt_eff >= {{(CNT_W-8){1'b0}}, cfg.trigger_ticks}) begin
      ph_eff  = PH_WAIT_RISE;
      cnt_eff = '0;
    end
    if (ph_eff == PH_WAIT_RISE && item.echo_level) begin
      ph_eff  = PH_WAIT_FALL;
      cnt_eff = '0;
    end
  end

  assign cnt_inc     = cnt_eff + CNT_W'(1);
  assign timeout_hit = cnt_inc > {{(CNT_W-TICK_W){1'b0}}, cfg.timeout_ticks};
  assign prod        = PROD_W'(cnt_eff[TICK_W-1:0]) * PROD_W'(DIST_MUL);

  // next state
  always_comb begin
    phase_next       = PH_IDLE;
    phase_count_next = '0;
    unique case (ph_eff)
      PH_IDLE: begin
        phase_next       = PH_IDLE;
        phase_count_next = '0;
      end
      PH_SETTLE, PH_TRIGGER: begin
        phase_next       = ph_eff;
        phase_count_next = cnt_inc;
      end
      PH_WAIT_RISE: begin
        if (!timeout_hit) begin
          phase_next       = PH_WAIT_RISE;
          phase_count_next = cnt_inc;
        end
      end
      PH_WAIT_FALL: begin
        if (item.echo_level && !timeout_hit) begin
          phase_next       = PH_WAIT_FALL;
          phase_count_next = cnt_inc;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        phase_count_next = '0;
      end
    endcase
  end

  // result for this tick
  always_comb begin
    res = '0;
    unique case (ph_eff)
      PH_IDLE: ;
      PH_SETTLE: begin
        res.drive_enable = 1'b1;
        res.busy_res     = 1'b1;
      end
      PH_TRIGGER: begin
        res.drive_enable = 1'b1;
        res.drive_level  = 1'b1;
        res.busy_res     = 1'b1;
      end
      PH_WAIT_RISE: begin
        if (timeout_hit) begin
          res.done_res  = 1'b1;
          res.timed_out = 1'b1;
        end else begin
          res.busy_res = 1'b1;
        end
      end
      PH_WAIT_FALL: begin
        if (!item.echo_level) begin
          res.done_res       = 1'b1;
          res.pulse_ticks    = cnt_eff[TICK_W-1:0];
          res.distance_q8_cm = prod[PROD_W-1:8];
        end else if (timeout_hit) begin
          res.done_res      = 1'b1;
          res.timed_out     = 1'b1;
          res.timeout_phase = 1'b1;
        end else begin
          res.busy_res = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_count <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      phase_count <= phase_count_next;
    end
  end

endmodule

[verif/testbench.sv]
// Self-checking bench for ultrasonic_echo_ranger: drives tick transfers and
// register writes, predicts every result in step and checks it field by field.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
`timescale 1ns / 1ps

module testbench;
  import uer_pkg::*;

  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         SETTLE_GAP  = 4;
  localparam int         END_GAP     = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  uer_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  uer_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // pending ticks and the results they must produce
  uer_in_t  tick_q[$];
  uer_out_t echo_result_q[$];

  // shadow of the block's registers and sequencer state
  logic [7:0]  cfg_settle  = SETTLE_RST;
  logic [7:0]  cfg_trigger = TRIGGER_RST;
  logic [15:0] cfg_timeout = TIMEOUT_RST;
  phase_t      rng_phase   = PH_IDLE;
  logic [16:0] rng_count   = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int results_seen = 0;
  int ticks_queued = 0;
  int stall_cycles = 0;

  ultrasonic_echo_ranger uut (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // expected result of one tick; advances the shadow sequencer
  function automatic uer_out_t ranger_next(logic start, logic echo);
    uer_out_t          res;
    logic [PROD_W-1:0] prod;
    res = '0;
    if (rng_phase == PH_IDLE) begin
      if (!start) return res;
      rng_phase = PH_SETTLE;
      rng_count = '0;
    end
    if (rng_phase == PH_SETTLE && rng_count >= cfg_settle) begin
      rng_phase = PH_TRIGGER;
      rng_count = '0;
    end
    if (rng_phase == PH_TRIGGER && rng_count >= cfg_trigger) begin
      rng_phase = PH_WAIT_RISE;
      rng_count = '0;
    end
    if (rng_phase == PH_SETTLE || rng_phase == PH_TRIGGER) begin
      res.drive_enable = 1'b1;
      res.drive_level  = (rng_phase == PH_TRIGGER);
      res.busy_res     = 1'b1;
      rng_count++;
      return res;
    end
    if (rng_phase == PH_WAIT_RISE) begin
      if (echo) begin
        // rising tick is already the first counted high tick
        rng_phase = PH_WAIT_FALL;
        rng_count = '0;
      end else begin
        rng_count++;
        if (rng_count > cfg_timeout) begin
          res.done_res  = 1'b1;
          res.timed_out = 1'b1;
          rng_phase     = PH_IDLE;
          rng_count     = '0;
        end else begin
          res.busy_res = 1'b1;
        end
        return res;
      end
    end
    if (!echo) begin
      res.done_res       = 1'b1;
      res.pulse_ticks    = rng_count[TICK_W-1:0];
      prod               = PROD_W'(res.pulse_ticks) * PROD_W'(DIST_MUL);
      res.distance_q8_cm = prod[PROD_W-1:8];
      rng_phase          = PH_IDLE;
      rng_count          = '0;
      return res;
    end
    rng_count++;
    if (rng_count > cfg_timeout) begin
      res.done_res      = 1'b1;
      res.timed_out     = 1'b1;
      res.timeout_phase = 1'b1;
      rng_phase         = PH_IDLE;
      rng_count         = '0;
    end else begin
      res.busy_res = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watches both sides: checks results first, then predicts the tick taken
  always @(posedge clk) begin : monitor
    uer_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (echo_result_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", results_seen));
        end else begin
          want = echo_result_q.pop_front();
          check_field("drive_enable", 32'(out_data.drive_enable),
                      32'(want.drive_enable));
          check_field("drive_level", 32'(out_data.drive_level),
                      32'(want.drive_level));
          check_field("busy_res", 32'(out_data.busy_res), 32'(want.busy_res));
          check_field("done_res", 32'(out_data.done_res), 32'(want.done_res));
          check_field("timed_out", 32'(out_data.timed_out), 32'(want.timed_out));
          check_field("timeout_phase", 32'(out_data.timeout_phase),
                      32'(want.timeout_phase));
          check_field("pulse_ticks", 32'(out_data.pulse_ticks),
                      32'(want.pulse_ticks));
          check_field("distance_q8_cm", 32'(out_data.distance_q8_cm),
                      32'(want.distance_q8_cm));
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        echo_result_q.push_back(ranger_next(in_data.start_request, in_data.echo_level));
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SETTLE:  cfg_settle  = val[7:0];
      CFG_TRIGGER: cfg_trigger = val[7:0];
      CFG_TIMEOUT: cfg_timeout = val;
      default: ;
    endcase
  endtask

  // upper bytes carry junk: only the low bits must stick
  task automatic configure(input logic [7:0] s, input logic [7:0] t,
                           input logic [15:0] tmo);
    write_reg(CFG_SETTLE, {8'($urandom), s});
    write_reg(CFG_TRIGGER, {8'($urandom), t});
    write_reg(CFG_TIMEOUT, tmo);
    @(negedge clk);
  endtask

  task automatic push_tick(input logic s, input logic e);
    uer_in_t it;
    it.start_request = s;
    it.echo_level    = e;
    tick_q.push_back(it);
    ticks_queued++;
  endtask

  // one measurement: start, drive ticks with noise on the pin, rise_zeros
  // low ticks, ones high ticks, and a closing low tick if asked
  task automatic add_run(input int rise_zeros, input int ones, input bit closed);
    int pre;
    int total;
    pre   = int'(cfg_settle) + int'(cfg_trigger);
    total = pre + rise_zeros + ones + (closed ? 1 : 0);
    for (int k = 0; k < total; k++) begin
      if (k == 0)
        push_tick(1'b1, (k < pre) ? 1'($urandom) : (rise_zeros == 0 && ones != 0));
      else if (k < pre)
        push_tick($urandom_range(3) == 0, 1'($urandom));
      else
        push_tick($urandom_range(3) == 0, k >= pre + rise_zeros && k < pre + rise_zeros + ones);
    end
  endtask

  task automatic add_random_seq();
    int mode;
    int tmo;
    int rmax;
    int hmax;
    tmo  = int'(cfg_timeout);
    mode = $urandom_range(9);
    rmax = (tmo < 20) ? tmo : 20;
    hmax = (tmo < 60) ? tmo : 60;
    if (mode == 8) begin
      repeat ($urandom_range(1, 8)) push_tick(1'($urandom), 1'($urandom));
    end else if (mode == 9) begin
      repeat ($urandom_range(1, 5)) push_tick(1'b0, 1'($urandom));
    end else if (tmo == 0) begin
      if (mode[0]) add_run(0, 1, 1'b0);
      else         add_run(1, 0, 1'b0);
    end else if (mode == 6 && tmo <= 100) begin
      add_run(tmo + 1, 0, 1'b0);
    end else if (mode == 7 && tmo <= 100) begin
      add_run($urandom_range(0, rmax), tmo + 1, 1'b0);
    end else begin
      add_run($urandom_range(0, rmax), $urandom_range(1, hmax), 1'b1);
    end
  endtask

  task automatic fill_random(input int n);
    int first;
    first = ticks_queued;
    while (ticks_queued - first < n) add_random_seq();
  endtask

  // hold the sender until every queued tick has its result back
  task automatic drain();
    do @(negedge clk); while (tick_q.size() != 0 || in_valid || echo_result_q.size() != 0);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values; minimal pulse; start on the ending tick is ignored
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    add_run(0, 1, 1'b1);
    add_run(2, 3, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    drain();

    // zero settle, zero trigger, zero timeout; unknown index ignored
    write_reg(CFG_SETTLE, 16'hFF00);
    write_reg(CFG_TRIGGER, 16'h0100);
    write_reg(CFG_TIMEOUT, 16'h0000);
    write_reg(CFG_UNUSED, 16'hFFFF);
    @(negedge clk);
    add_run(0, 1, 1'b0);
    add_run(1, 0, 1'b0);
    drain();

    configure(8'd0, 8'd1, 16'd1);
    add_run(1, 1, 1'b1);
    add_run(0, 2, 1'b0);
    drain();

    send_idle = 37;
    recv_idle = 85;
    configure(8'd3, 8'd4, 16'd40);
    fill_random(110);
    drain();
    configure(8'd1, 8'd2, 16'd7);
    fill_random(110);
    drain();

    send_idle = 85;
    recv_idle = 37;
    configure(8'd0, 8'd0, 16'd12);
    fill_random(110);
    drain();
    configure(8'd6, 8'd1, 16'd3);
    fill_random(110);
    drain();

    send_idle = 0;
    recv_idle = 0;
    configure(SETTLE_RST, TRIGGER_RST, TIMEOUT_RST);
    fill_random(110);
    drain();

    // widest settings
    configure(8'd255, 8'd255, 16'hFFFF);
    add_run(3, 7, 1'b1);
    drain();

    repeat (END_GAP) @(posedge clk);
    if (mismatches == 0 && echo_result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
